@@ rtl/sprt_pkg.sv @@
`default_nettype none

package sprt_pkg;

	localparam int NUM_VERTICES_DEF = 10;
	localparam int ANGLE_BITS_DEF   = 16;

	localparam int COORD_W  = 12;
	localparam int VERT_W   = 13;
	localparam int COLOUR_W = 4;
	localparam int TRIG_W   = 17;
	localparam int OFS_W    = 6;

	localparam int ROM_SIZE  = 10;
	localparam int ROM_IDX_W = $clog2(ROM_SIZE);

	localparam int PHASE_W         = 32;
	localparam int CORDIC_W        = 32;
	localparam int CORDIC_STEPS    = 30;
	localparam int STEPS_PER_CYCLE = 3;
	localparam int CORDIC_CYCLES   = CORDIC_STEPS / STEPS_PER_CYCLE;
	localparam int STEP_W          = $clog2(CORDIC_STEPS);
	localparam int CYC_W           = $clog2(CORDIC_CYCLES);

	localparam int QUEUE_DEPTH = 2;

	localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sh26DD3B6A;

	typedef logic [ROM_IDX_W-1:0] rom_idx_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0]  c;
		logic signed [TRIG_W-1:0]  s;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [COLOUR_W-1:0]       colour;
	} trig_item_t;

	function automatic logic [CORDIC_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
		case (i)
			5'd0:    return 32'h20000000;
			5'd1:    return 32'h12E4051E;
			5'd2:    return 32'h09FB385B;
			5'd3:    return 32'h051111D4;
			5'd4:    return 32'h028B0D43;
			5'd5:    return 32'h0145D7E1;
			5'd6:    return 32'h00A2F61E;
			5'd7:    return 32'h00517C55;
			5'd8:    return 32'h0028BE53;
			5'd9:    return 32'h00145F2F;
			5'd10:   return 32'h000A2F98;
			5'd11:   return 32'h000517CC;
			5'd12:   return 32'h00028BE6;
			5'd13:   return 32'h000145F3;
			5'd14:   return 32'h0000A2FA;
			5'd15:   return 32'h0000517D;
			5'd16:   return 32'h000028BE;
			5'd17:   return 32'h0000145F;
			5'd18:   return 32'h00000A30;
			5'd19:   return 32'h00000518;
			5'd20:   return 32'h0000028C;
			5'd21:   return 32'h00000146;
			5'd22:   return 32'h000000A3;
			5'd23:   return 32'h00000051;
			5'd24:   return 32'h00000029;
			5'd25:   return 32'h00000014;
			5'd26:   return 32'h0000000A;
			5'd27:   return 32'h00000005;
			5'd28:   return 32'h00000003;
			5'd29:   return 32'h00000001;
			default: return 32'h00000000;
		endcase
	endfunction

	function automatic logic signed [OFS_W-1:0] star_x(input rom_idx_t i);
		case (i)
			4'd0:    return 6'sd0;
			4'd1:    return 6'sd5;
			4'd2:    return 6'sd20;
			4'd3:    return 6'sd8;
			4'd4:    return 6'sd14;
			4'd5:    return 6'sd0;
			4'd6:    return -6'sd14;
			4'd7:    return -6'sd8;
			4'd8:    return -6'sd20;
			4'd9:    return -6'sd5;
			default: return 6'sd0;
		endcase
	endfunction

	function automatic logic signed [OFS_W-1:0] star_y(input rom_idx_t i);
		case (i)
			4'd0:    return -6'sd20;
			4'd1:    return -6'sd7;
			4'd2:    return -6'sd7;
			4'd3:    return 6'sd4;
			4'd4:    return 6'sd20;
			4'd5:    return 6'sd10;
			4'd6:    return 6'sd20;
			4'd7:    return 6'sd4;
			4'd8:    return -6'sd7;
			4'd9:    return -6'sd7;
			default: return 6'sd0;
		endcase
	endfunction

endpackage

`default_nettype wire

@@ rtl/sprt_sincos.sv @@
`default_nettype none

module sprt_sincos #(
	parameter int ANGLE_BITS = sprt_pkg::ANGLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sprt_pkg::COORD_W-1:0] centre_x,
	input  logic signed [sprt_pkg::COORD_W-1:0] centre_y,
	input  logic [ANGLE_BITS-1:0]               angle,
	input  logic [sprt_pkg::COLOUR_W-1:0]       colour,
	output logic                                push_valid,
	input  logic                                push_ready,
	output sprt_pkg::trig_item_t                push_data
);
	import sprt_pkg::*;

	logic                       hold_valid_q;
	logic signed [COORD_W-1:0]  hold_cx_q;
	logic signed [COORD_W-1:0]  hold_cy_q;
	logic [ANGLE_BITS-1:0]      hold_angle_q;
	logic [COLOUR_W-1:0]        hold_col_q;

	logic                       busy_q;
	logic                       done_q;
	logic [CYC_W-1:0]           cyc_q;
	logic signed [CORDIC_W-1:0] x_q;
	logic signed [CORDIC_W-1:0] y_q;
	logic signed [CORDIC_W-1:0] z_q;
	logic [1:0]                 quad_q;
	logic signed [COORD_W-1:0]  cx_q;
	logic signed [COORD_W-1:0]  cy_q;
	logic [COLOUR_W-1:0]        col_q;

	logic                       in_fire;
	logic                       push_fire;
	logic                       load;
	logic                       last_cyc;
	logic [PHASE_W-1:0]         phase;
	logic [PHASE_W-1:0]         qsum;
	logic [1:0]                 quad;
	logic signed [CORDIC_W-1:0] z0;
	logic signed [CORDIC_W-1:0] x_nx;
	logic signed [CORDIC_W-1:0] y_nx;
	logic signed [CORDIC_W-1:0] z_nx;
	logic signed [TRIG_W-1:0]   cr;
	logic signed [TRIG_W-1:0]   sr;

	function automatic logic signed [TRIG_W-1:0] q15_round(input logic signed [CORDIC_W-1:0] v);
		logic signed [CORDIC_W:0] r;
		r = (signed'({v[CORDIC_W-1], v}) + 33'sd16384) >>> 15;
		if (r > 33'sd32768)
			return 17'sd32768;
		else if (r < -33'sd32768)
			return -17'sd32768;
		else
			return r[TRIG_W-1:0];
	endfunction

	assign in_ready  = !hold_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign push_fire = done_q && push_ready;
	assign load      = hold_valid_q && !busy_q && (!done_q || push_fire);
	assign last_cyc  = (cyc_q == CYC_W'(CORDIC_CYCLES - 1));

	// nearest quadrant and signed residual
	assign phase = PHASE_W'(hold_angle_q) << (PHASE_W - ANGLE_BITS);
	assign qsum  = phase + 32'h2000_0000;
	assign quad  = qsum[PHASE_W-1:PHASE_W-2];
	assign z0    = signed'(phase - {quad, 30'd0});

	always_comb begin : cordic_steps
		logic signed [CORDIC_W-1:0] xv;
		logic signed [CORDIC_W-1:0] yv;
		logic signed [CORDIC_W-1:0] zv;
		logic signed [CORDIC_W-1:0] dx;
		logic signed [CORDIC_W-1:0] dy;
		logic [STEP_W-1:0]          sh;
		xv = x_q;
		yv = y_q;
		zv = z_q;
		for (int j = 0; j < STEPS_PER_CYCLE; j++) begin
			sh = STEP_W'(int'(cyc_q) * STEPS_PER_CYCLE + j);
			dx = yv >>> sh;
			dy = xv >>> sh;
			if (!zv[CORDIC_W-1]) begin
				xv = xv - dx;
				yv = yv + dy;
				zv = zv - signed'(atan_lut(sh));
			end else begin
				xv = xv + dx;
				yv = yv - dy;
				zv = zv + signed'(atan_lut(sh));
			end
		end
		x_nx = xv;
		y_nx = yv;
		z_nx = zv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			busy_q       <= 1'b0;
			done_q       <= 1'b0;
			cyc_q        <= '0;
		end else begin
			if (in_fire)
				hold_valid_q <= 1'b1;
			else if (load)
				hold_valid_q <= 1'b0;

			if (load) begin
				busy_q <= 1'b1;
				cyc_q  <= '0;
			end else if (busy_q) begin
				if (last_cyc)
					busy_q <= 1'b0;
				else
					cyc_q <= cyc_q + 1'b1;
			end

			if (busy_q && last_cyc)
				done_q <= 1'b1;
			else if (push_fire)
				done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			hold_cx_q    <= centre_x;
			hold_cy_q    <= centre_y;
			hold_angle_q <= angle;
			hold_col_q   <= colour;
		end
		if (load) begin
			x_q    <= CORDIC_X0;
			y_q    <= '0;
			z_q    <= z0;
			quad_q <= quad;
			cx_q   <= hold_cx_q;
			cy_q   <= hold_cy_q;
			col_q  <= hold_col_q;
		end else if (busy_q) begin
			x_q <= x_nx;
			y_q <= y_nx;
			z_q <= z_nx;
		end
	end

	assign cr = q15_round(x_q);
	assign sr = q15_round(y_q);

	always_comb begin
		push_data.cx     = cx_q;
		push_data.cy     = cy_q;
		push_data.colour = col_q;
		case (quad_q)
			2'd0: begin
				push_data.c = cr;
				push_data.s = sr;
			end
			2'd1: begin
				push_data.c = -sr;
				push_data.s = cr;
			end
			2'd2: begin
				push_data.c = -cr;
				push_data.s = -sr;
			end
			default: begin
				push_data.c = sr;
				push_data.s = -cr;
			end
		endcase
	end

	assign push_valid = done_q;

endmodule

`default_nettype wire

@@ rtl/sprt_queue.sv @@
`default_nettype none

module sprt_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  sprt_pkg::trig_item_t push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output sprt_pkg::trig_item_t pop_data
);
	import sprt_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	trig_item_t       entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;
	logic             pop_fire;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop_fire)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push_fire && !pop_fire)
				count_q <= count_q + 1'b1;
			else if (pop_fire && !push_fire)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

@@ rtl/sprt_vertex.sv @@
`default_nettype none

module sprt_vertex #(
	parameter int NUM_VERTICES = sprt_pkg::NUM_VERTICES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pop_valid,
	output logic                               pop_ready,
	input  sprt_pkg::trig_item_t               pop_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [sprt_pkg::VERT_W-1:0] vertex_x,
	output logic signed [sprt_pkg::VERT_W-1:0] vertex_y,
	output logic [sprt_pkg::COLOUR_W-1:0]      vertex_colour,
	output logic                               last_vertex
);
	import sprt_pkg::*;

	localparam int IDX_W  = $clog2(NUM_VERTICES + 1);
	localparam int PROD_W = 24;

	logic [IDX_W-1:0]         idx_q;
	rom_idx_t                 rom_q;
	logic                     out_valid_q;
	logic signed [VERT_W-1:0] vx_out_q;
	logic signed [VERT_W-1:0] vy_out_q;
	logic [COLOUR_W-1:0]      col_out_q;
	logic                     last_out_q;

	logic                     adv;
	logic                     closing;
	rom_idx_t                 ri;
	logic signed [PROD_W-1:0] ox;
	logic signed [PROD_W-1:0] oy;
	logic signed [PROD_W-1:0] c_w;
	logic signed [PROD_W-1:0] s_w;
	logic signed [PROD_W-1:0] rx;
	logic signed [PROD_W-1:0] ry;
	logic signed [PROD_W-1:0] tx;
	logic signed [PROD_W-1:0] ty;
	logic signed [VERT_W-1:0] cx_w;
	logic signed [VERT_W-1:0] cy_w;
	logic signed [VERT_W-1:0] px;
	logic signed [VERT_W-1:0] py;

	assign adv       = pop_valid && (!out_valid_q || out_ready);
	assign closing   = (idx_q == IDX_W'(NUM_VERTICES));
	assign pop_ready = adv && closing;
	assign ri        = closing ? '0 : rom_q;

	assign ox  = PROD_W'(star_x(ri));
	assign oy  = PROD_W'(star_y(ri));
	assign c_w = PROD_W'(pop_data.c);
	assign s_w = PROD_W'(pop_data.s);
	assign rx  = ox * c_w - oy * s_w;
	assign ry  = ox * s_w + oy * c_w;

	// divide by 2^15 rounding toward zero
	assign tx = (rx + (rx[PROD_W-1] ? 24'sd32767 : 24'sd0)) >>> 15;
	assign ty = (ry + (ry[PROD_W-1] ? 24'sd32767 : 24'sd0)) >>> 15;

	assign cx_w = VERT_W'(pop_data.cx);
	assign cy_w = VERT_W'(pop_data.cy);
	assign px   = cx_w + signed'(tx[VERT_W-1:0]);
	assign py   = cy_w + signed'(ty[VERT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rom_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				if (closing) begin
					idx_q <= '0;
					rom_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
					rom_q <= (rom_q == ROM_IDX_W'(ROM_SIZE - 1)) ? '0 : rom_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_out_q   <= px;
			vy_out_q   <= py;
			col_out_q  <= pop_data.colour;
			last_out_q <= closing;
		end
	end

	assign out_valid     = out_valid_q;
	assign vertex_x      = vx_out_q;
	assign vertex_y      = vy_out_q;
	assign vertex_colour = col_out_q;
	assign last_vertex   = last_out_q;

endmodule

`default_nettype wire

@@ rtl/star_polygon_rotate_translate.sv @@
// Rotates a fixed star outline by a binary angle (2^ANGLE_BITS units per turn) and moves it
// to a centre point. Each accepted item yields NUM_VERTICES + 1 results: the vertices in
// order, then the first vertex again with last_vertex set, all carrying the item's colour.
// Sine and cosine come from a CORDIC rotator doing three iterations per cycle over its 30
// iterations; the vertex stage emits one result per cycle while an item is queued and
// out_ready is high. A two-entry queue between rotator and vertex stage lets the next
// angle be worked out while the current polygon drains, and a holding register takes the
// next item while the rotator is busy. An accepted item passes through the holding
// register, the rotator, the queue and the registered vertex stage before its first
// result appears.
`default_nettype none

module star_polygon_rotate_translate #(
	parameter int NUM_VERTICES = sprt_pkg::NUM_VERTICES_DEF,
	parameter int ANGLE_BITS   = sprt_pkg::ANGLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [sprt_pkg::COORD_W-1:0] centre_x,
	input  logic signed [sprt_pkg::COORD_W-1:0] centre_y,
	input  logic [ANGLE_BITS-1:0]               angle,
	input  logic [sprt_pkg::COLOUR_W-1:0]       colour,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sprt_pkg::VERT_W-1:0]  vertex_x,
	output logic signed [sprt_pkg::VERT_W-1:0]  vertex_y,
	output logic [sprt_pkg::COLOUR_W-1:0]       vertex_colour,
	output logic                                last_vertex
);
	import sprt_pkg::*;

	logic       push_valid;
	logic       push_ready;
	trig_item_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	trig_item_t pop_data;

	sprt_sincos #(
		.ANGLE_BITS(ANGLE_BITS)
	) u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.centre_x  (centre_x),
		.centre_y  (centre_y),
		.angle     (angle),
		.colour    (colour),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	sprt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	sprt_vertex #(
		.NUM_VERTICES(NUM_VERTICES)
	) u_vertex (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.vertex_colour(vertex_colour),
		.last_vertex  (last_vertex)
	);

endmodule

`default_nettype wire

@@ rtl/sprt_checker.sv @@
`default_nettype none

module sprt_checker #(
	parameter int NUM_VERTICES = sprt_pkg::NUM_VERTICES_DEF
) (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire signed [sprt_pkg::VERT_W-1:0]  vertex_x,
	input wire signed [sprt_pkg::VERT_W-1:0]  vertex_y,
	input wire [sprt_pkg::COLOUR_W-1:0]       vertex_colour,
	input wire                                last_vertex
);
	import sprt_pkg::*;

	localparam int CNT_W = $clog2(NUM_VERTICES + 1) + 1;

	logic [3:0]          pending_q;
	logic [CNT_W-1:0]    vert_cnt_q;
	logic                mid_q;
	logic [COLOUR_W-1:0] colour_prev_q;
	logic                in_fire;
	logic                out_fire;
	logic                close_fire;

	assign in_fire    = in_valid && in_ready;
	assign out_fire   = out_valid && out_ready;
	assign close_fire = out_fire && last_vertex;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			vert_cnt_q <= '0;
			mid_q      <= 1'b0;
		end else begin
			if (in_fire && !close_fire)
				pending_q <= pending_q + 1'b1;
			else if (close_fire && !in_fire)
				pending_q <= pending_q - 1'b1;
			if (out_fire) begin
				vert_cnt_q <= last_vertex ? '0 : vert_cnt_q + 1'b1;
				mid_q      <= !last_vertex;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire)
			colour_prev_q <= vertex_colour;
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex_x) && $stable(vertex_y)
			&& $stable(vertex_colour) && $stable(last_vertex))
		else $error("stalled result changed");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result with no item in flight");

	a_close_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> (last_vertex == (vert_cnt_q == CNT_W'(NUM_VERTICES))))
		else $error("closing vertex at wrong position");

	a_colour_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && mid_q |-> vertex_colour == colour_prev_q)
		else $error("colour changed within one polygon");

endmodule

bind star_polygon_rotate_translate sprt_checker #(
	.NUM_VERTICES(NUM_VERTICES)
) u_sprt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.vertex_x     (vertex_x),
	.vertex_y     (vertex_y),
	.vertex_colour(vertex_colour),
	.last_vertex  (last_vertex)
);

`default_nettype wire
